// ===== rtl/core/sbsq_pkg.sv =====
// Shared types and constants of the stereo blob sample qualifier.
package sbsq_pkg;

  localparam int COORD_W    = 8;
  localparam int CENTRE_W   = 9;
  localparam int CENTRE_MAX = 510;
  localparam int MEAN_W     = 11;
  localparam int SPREAD_W   = 11;
  localparam int TOL_W      = 11;
  localparam int COUNT_W    = 10;
  localparam int BOUNDS_W   = 32;
  localparam int SQ_W       = 2 * MEAN_W + 1;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_CAM_A_WINDOW    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CAM_B_WINDOW    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_NOISE_TOLERANCE = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MIN_STEP        = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_COUNT    = 3'd4;

  localparam logic [BOUNDS_W-1:0] CAM_WINDOW_RESET    = 32'h8FB0_010C;
  localparam logic [TOL_W-1:0]    NOISE_TOL_RESET     = 11'd8;
  localparam logic [TOL_W-1:0]    MIN_STEP_RESET      = 11'd160;
  localparam logic [COUNT_W-1:0]  TARGET_COUNT_RESET  = 10'd32;

  typedef struct packed {
    logic               single_blobs;
    logic [COORD_W-1:0] a_left;
    logic [COORD_W-1:0] a_top;
    logic [COORD_W-1:0] a_right;
    logic [COORD_W-1:0] a_bottom;
    logic [COORD_W-1:0] b_left;
    logic [COORD_W-1:0] b_top;
    logic [COORD_W-1:0] b_right;
    logic [COORD_W-1:0] b_bottom;
  } frame_t;

  typedef struct packed {
    logic               accepted;
    logic [MEAN_W-1:0]  mean_a_x;
    logic [MEAN_W-1:0]  mean_a_y;
    logic [MEAN_W-1:0]  mean_b_x;
    logic [MEAN_W-1:0]  mean_b_y;
    logic [COUNT_W-1:0] sample_total;
    logic               capture_done;
  } result_t;

  // Box centre in half pixels: left+right, top+bottom.
  typedef struct packed {
    logic [CENTRE_W-1:0] x;
    logic [CENTRE_W-1:0] y;
  } centre_t;

  // Window stage to decision stage.
  typedef struct packed {
    logic                pushed;
    logic                full;
    logic [MEAN_W-1:0]   mean_a_x;
    logic [MEAN_W-1:0]   mean_a_y;
    logic [MEAN_W-1:0]   mean_b_x;
    logic [MEAN_W-1:0]   mean_b_y;
    logic [SPREAD_W-1:0] spread_a_x;
    logic [SPREAD_W-1:0] spread_a_y;
    logic [SPREAD_W-1:0] spread_b_x;
    logic [SPREAD_W-1:0] spread_b_y;
  } win_stat_t;

endpackage

// ===== rtl/core/sbsq_stream_if.sv =====
// Valid/ready stream channel carrying one payload word.
interface sbsq_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/sbsq_window.sv =====
// Centre windows of both cameras: push, fill count, means and spreads, one registered stage.
module sbsq_window #(
  parameter int DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             advance,
  input  logic                             done,
  input  sbsq_pkg::frame_t                 item,
  input  logic [sbsq_pkg::BOUNDS_W-1:0]    bounds_a,
  input  logic [sbsq_pkg::BOUNDS_W-1:0]    bounds_b,
  output sbsq_pkg::win_stat_t              stat
);

  localparam int FILL_W  = $clog2(DEPTH + 1);
  localparam int SUM_W   = $clog2(DEPTH * sbsq_pkg::CENTRE_MAX + 1);
  localparam int NUM_W   = $clog2(4 * DEPTH * sbsq_pkg::CENTRE_MAX + DEPTH / 2 + 1);
  localparam int SHIFT   = NUM_W + FILL_W;
  localparam int RECIP_W = SHIFT + 1;
  localparam int PROD_W  = NUM_W + RECIP_W;
  localparam int CW      = sbsq_pkg::CENTRE_W;
  localparam int MW      = sbsq_pkg::MEAN_W;
  localparam int SW      = sbsq_pkg::SPREAD_W;

  function automatic logic at_edge(input logic [sbsq_pkg::BOUNDS_W-1:0] b,
                                   input logic [sbsq_pkg::COORD_W-1:0] l,
                                   input logic [sbsq_pkg::COORD_W-1:0] t,
                                   input logic [sbsq_pkg::COORD_W-1:0] r,
                                   input logic [sbsq_pkg::COORD_W-1:0] bt);
    return (l <= b[7:0]) || (t <= b[15:8]) || (r >= b[23:16]) || (bt >= b[31:24]);
  endfunction

  sbsq_pkg::centre_t win_a [DEPTH];
  sbsq_pkg::centre_t win_b [DEPTH];
  sbsq_pkg::centre_t win_a_next [DEPTH];
  sbsq_pkg::centre_t win_b_next [DEPTH];
  sbsq_pkg::centre_t shift_a [DEPTH];
  sbsq_pkg::centre_t shift_b [DEPTH];
  sbsq_pkg::centre_t new_a, new_b;
  logic [FILL_W-1:0]  fill, fill_new;
  logic               full, push_en, clear;
  logic [RECIP_W-1:0] recip [2**FILL_W];
  logic [RECIP_W-1:0] recip_sel;
  logic [SUM_W-1:0]   sum_ax, sum_ay, sum_bx, sum_by;
  logic [CW-1:0]      lo_ax, lo_ay, lo_bx, lo_by, hi_ax, hi_ay, hi_bx, hi_by;
  logic [PROD_W-1:0]  prod_ax, prod_ay, prod_bx, prod_by;

  // Reciprocals ceil(2^SHIFT / n), exact for every numerator the window can give.
  for (genvar n = 0; n < 2**FILL_W; n++) begin : g_recip
    localparam longint unsigned DIV = (n == 0) ? 1 : n;
    localparam longint unsigned R =
      (n >= 1 && n <= DEPTH) ? (((64'd1 << SHIFT) + DIV - 1) / DIV) : 64'd0;
    assign recip[n] = RECIP_W'(R);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_shift
    if (i < DEPTH - 1) begin : g_mid
      assign shift_a[i] = win_a[i+1];
      assign shift_b[i] = win_b[i+1];
    end else begin : g_last
      assign shift_a[i] = new_a;
      assign shift_b[i] = new_b;
    end
  end

  always_comb begin
    new_a.x = CW'(item.a_left) + CW'(item.a_right);
    new_a.y = CW'(item.a_top) + CW'(item.a_bottom);
    new_b.x = CW'(item.b_left) + CW'(item.b_right);
    new_b.y = CW'(item.b_top) + CW'(item.b_bottom);
    push_en = item.single_blobs && !done
              && !at_edge(bounds_a, item.a_left, item.a_top, item.a_right, item.a_bottom)
              && !at_edge(bounds_b, item.b_left, item.b_top, item.b_right, item.b_bottom);
    clear    = !item.single_blobs && !done;
    full     = (fill == FILL_W'(DEPTH));
    fill_new = full ? fill : fill + 1'b1;
    for (int i = 0; i < DEPTH; i++) begin
      if (full) begin
        win_a_next[i] = shift_a[i];
        win_b_next[i] = shift_b[i];
      end else begin
        win_a_next[i] = (fill == FILL_W'(i)) ? new_a : win_a[i];
        win_b_next[i] = (fill == FILL_W'(i)) ? new_b : win_b[i];
      end
    end
  end

  // Sums over the filled entries; extremes over all entries, used only when full.
  always_comb begin
    sum_ax = '0; sum_ay = '0; sum_bx = '0; sum_by = '0;
    lo_ax = '1; lo_ay = '1; lo_bx = '1; lo_by = '1;
    hi_ax = '0; hi_ay = '0; hi_bx = '0; hi_by = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (FILL_W'(i) < fill_new) begin
        sum_ax = sum_ax + SUM_W'(win_a_next[i].x);
        sum_ay = sum_ay + SUM_W'(win_a_next[i].y);
        sum_bx = sum_bx + SUM_W'(win_b_next[i].x);
        sum_by = sum_by + SUM_W'(win_b_next[i].y);
      end
      if (win_a_next[i].x < lo_ax) lo_ax = win_a_next[i].x;
      if (win_a_next[i].y < lo_ay) lo_ay = win_a_next[i].y;
      if (win_b_next[i].x < lo_bx) lo_bx = win_b_next[i].x;
      if (win_b_next[i].y < lo_by) lo_by = win_b_next[i].y;
      if (win_a_next[i].x > hi_ax) hi_ax = win_a_next[i].x;
      if (win_a_next[i].y > hi_ay) hi_ay = win_a_next[i].y;
      if (win_b_next[i].x > hi_bx) hi_bx = win_b_next[i].x;
      if (win_b_next[i].y > hi_by) hi_by = win_b_next[i].y;
    end
  end

  // Rounded mean: (4*sum + n/2) / n through the reciprocal table.
  always_comb begin
    recip_sel = recip[fill_new];
    prod_ax = PROD_W'(NUM_W'({sum_ax, 2'b00}) + NUM_W'(fill_new >> 1)) * PROD_W'(recip_sel);
    prod_ay = PROD_W'(NUM_W'({sum_ay, 2'b00}) + NUM_W'(fill_new >> 1)) * PROD_W'(recip_sel);
    prod_bx = PROD_W'(NUM_W'({sum_bx, 2'b00}) + NUM_W'(fill_new >> 1)) * PROD_W'(recip_sel);
    prod_by = PROD_W'(NUM_W'({sum_by, 2'b00}) + NUM_W'(fill_new >> 1)) * PROD_W'(recip_sel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (advance) begin
      if (push_en) begin
        fill <= fill_new;
      end else if (clear) begin
        fill <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && push_en) begin
      win_a <= win_a_next;
      win_b <= win_b_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stat.pushed     <= push_en;
      stat.full       <= (fill_new == FILL_W'(DEPTH));
      stat.mean_a_x   <= prod_ax[SHIFT +: MW];
      stat.mean_a_y   <= prod_ay[SHIFT +: MW];
      stat.mean_b_x   <= prod_bx[SHIFT +: MW];
      stat.mean_b_y   <= prod_by[SHIFT +: MW];
      stat.spread_a_x <= SW'({hi_ax - lo_ax, 2'b00});
      stat.spread_a_y <= SW'({hi_ay - lo_ay, 2'b00});
      stat.spread_b_x <= SW'({hi_bx - lo_bx, 2'b00});
      stat.spread_b_y <= SW'({hi_by - lo_by, 2'b00});
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(DEPTH))
    else $error("window fill beyond depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    advance && clear |=> fill == '0)
    else $error("multi-blob frame did not empty the windows");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    advance && push_en && !full |=> fill == $past(fill) + 1'b1)
    else $error("push into a partial window did not grow the fill");

endmodule

// ===== rtl/core/stereo_blob_sample_qualifier.sv =====
// Top level: APB registers, three-stage frame pipeline and sample decision.
// A result passes the input register, the window stage and the result register, in that
// order, after its frame word is accepted.
// Throughput: one frame per cycle while result.ready is high; each stage holds its word
// only while the next is full. The capture decision and counter update are made in the
// result stage. Reset clears the pipeline, the window fill and the sample count and
// loads the register defaults; window entries and the last sample hold no reset value.
module stereo_blob_sample_qualifier #(
  parameter int WINDOW_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  sbsq_stream_if.sink                       frame,
  sbsq_stream_if.source                     result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sbsq_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [sbsq_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [sbsq_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int CNT_W = sbsq_pkg::COUNT_W;
  localparam int SQ_W  = sbsq_pkg::SQ_W;
  localparam int MW    = sbsq_pkg::MEAN_W;

  function automatic logic [SQ_W-1:0] square(input logic [MW-1:0] v);
    return SQ_W'(v) * SQ_W'(v);
  endfunction

  function automatic logic [MW-1:0] abs_diff(input logic [MW-1:0] p, input logic [MW-1:0] q);
    return (p > q) ? p - q : q - p;
  endfunction

  logic [sbsq_pkg::BOUNDS_W-1:0] cam_a_window, cam_b_window;
  logic [sbsq_pkg::TOL_W-1:0]    noise_tolerance, min_step;
  logic [CNT_W-1:0]              target_count;
  logic [sbsq_pkg::REG_IDX_W-1:0] reg_idx;

  sbsq_pkg::frame_t    item;
  sbsq_pkg::win_stat_t stat;
  sbsq_pkg::result_t   res;
  logic                v1, v2, v3;
  logic                ready1, ready2, ready3, adv2, adv3;
  logic [CNT_W-1:0]    total, total_inc, total_next;
  logic [MW-1:0]       last_a_x, last_a_y, last_b_x, last_b_y;
  logic [SQ_W-1:0]     tol_sq, step_sq, spread_a_sq, spread_b_sq, dist_a_sq, dist_b_sq;
  logic                take, done_w;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[sbsq_pkg::APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_a_window    <= sbsq_pkg::CAM_WINDOW_RESET;
      cam_b_window    <= sbsq_pkg::CAM_WINDOW_RESET;
      noise_tolerance <= sbsq_pkg::NOISE_TOL_RESET;
      min_step        <= sbsq_pkg::MIN_STEP_RESET;
      target_count    <= sbsq_pkg::TARGET_COUNT_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        sbsq_pkg::REG_CAM_A_WINDOW:    cam_a_window    <= pwdata;
        sbsq_pkg::REG_CAM_B_WINDOW:    cam_b_window    <= pwdata;
        sbsq_pkg::REG_NOISE_TOLERANCE: noise_tolerance <= pwdata[sbsq_pkg::TOL_W-1:0];
        sbsq_pkg::REG_MIN_STEP:        min_step        <= pwdata[sbsq_pkg::TOL_W-1:0];
        sbsq_pkg::REG_TARGET_COUNT:    target_count    <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sbsq_pkg::REG_CAM_A_WINDOW:    prdata = cam_a_window;
      sbsq_pkg::REG_CAM_B_WINDOW:    prdata = cam_b_window;
      sbsq_pkg::REG_NOISE_TOLERANCE: prdata = sbsq_pkg::APB_DATA_W'(noise_tolerance);
      sbsq_pkg::REG_MIN_STEP:        prdata = sbsq_pkg::APB_DATA_W'(min_step);
      sbsq_pkg::REG_TARGET_COUNT:    prdata = sbsq_pkg::APB_DATA_W'(target_count);
      default:                       prdata = '0;
    endcase
  end

  // Stage handshakes
  assign ready3      = !v3 || result.ready;
  assign ready2      = !v2 || ready3;
  assign ready1      = !v1 || ready2;
  assign adv3        = v2 && ready3;
  assign adv2        = v1 && ready2;
  assign frame.ready = ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) v1 <= frame.valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid && ready1) begin
      item <= frame.data;
    end
  end

  sbsq_window #(
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .advance  (adv2),
    .done     (done_w),
    .item     (item),
    .bounds_a (cam_a_window),
    .bounds_b (cam_b_window),
    .stat     (stat)
  );

  // Decision stage
  always_comb begin
    tol_sq      = SQ_W'(noise_tolerance) * SQ_W'(noise_tolerance);
    step_sq     = SQ_W'(min_step) * SQ_W'(min_step);
    spread_a_sq = square(stat.spread_a_x) + square(stat.spread_a_y);
    spread_b_sq = square(stat.spread_b_x) + square(stat.spread_b_y);
    dist_a_sq   = square(abs_diff(stat.mean_a_x, last_a_x))
                  + square(abs_diff(stat.mean_a_y, last_a_y));
    dist_b_sq   = square(abs_diff(stat.mean_b_x, last_b_x))
                  + square(abs_diff(stat.mean_b_y, last_b_y));
    take = v2 && stat.pushed && stat.full
           && (spread_a_sq < tol_sq) && (spread_b_sq < tol_sq)
           && ((total == '0) || (dist_a_sq >= step_sq) || (dist_b_sq >= step_sq));
    total_inc  = total + 1'b1;
    total_next = take ? total_inc : total;
    // Capture state as seen by the frame entering the window stage.
    done_w = take ? (total_inc >= target_count) : (total >= target_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (adv3) begin
      total <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      if (take) begin
        last_a_x <= stat.mean_a_x;
        last_a_y <= stat.mean_a_y;
        last_b_x <= stat.mean_b_x;
        last_b_y <= stat.mean_b_y;
      end
      res.accepted     <= take;
      res.mean_a_x     <= stat.pushed ? stat.mean_a_x : '0;
      res.mean_a_y     <= stat.pushed ? stat.mean_a_y : '0;
      res.mean_b_x     <= stat.pushed ? stat.mean_b_x : '0;
      res.mean_b_y     <= stat.pushed ? stat.mean_b_y : '0;
      res.sample_total <= total_next;
      res.capture_done <= (total_next >= target_count);
    end
  end

  assign result.valid = v3;
  assign result.data  = res;

  a_accept_counts: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.accepted |-> result.data.sample_total != '0)
    else $error("accepted word carries zero sample total");

  a_total_steps: assert property (@(posedge clk) disable iff (rst)
    total != $past(total) |-> total == CNT_W'($past(total) + 1'b1))
    else $error("sample total moved by more than one");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready && v1 && v2 |-> !frame.ready)
    else $error("frame taken while every stage is full and stalled");

endmodule
